### rtl/core/ddo_pkg.sv
// Shared types, constants and the arctangent table for the odometry block.
`default_nettype none
package ddo_pkg;

    localparam int MUL_AW  = 64;
    localparam int MUL_BW  = 32;
    localparam int DIV_NW  = 64;
    localparam int DIV_DW  = 32;
    localparam int ANG_W   = 34;
    localparam int ATAN_N  = 30;
    localparam int ATAN_IW = 5;

    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang PI_Q30      = 34'sd3373259426;
    localparam t_ang HALF_PI_Q30 = 34'sd1686629713;
    localparam t_ang GAIN_Q30    = 34'sd652032874;

    localparam logic [2:0] CFG_CIRC     = 3'd0;
    localparam logic [2:0] CFG_BASE     = 3'd1;
    localparam logic [2:0] CFG_STILL_V  = 3'd2;
    localparam logic [2:0] CFG_STILL_W  = 3'd3;
    localparam logic [2:0] CFG_DEADBAND = 3'd4;

    function automatic logic [31:0] atan_q30(input logic [ATAN_IW-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000007;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/ddo_mul.sv
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module ddo_mul
    import ddo_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MUL_AW-1:0] i_a,
    input  wire logic [MUL_BW-1:0] i_b,
    output logic                   o_done,
    output logic [MUL_AW-1:0]      o_prod
);
    localparam int CW = $clog2(MUL_BW);

    logic [MUL_AW-1:0] r_a;
    logic [MUL_AW-1:0] r_acc;
    logic [MUL_BW-1:0] r_b;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[MUL_AW-2:0], 1'b0};
                r_b   <= {1'b0, r_b[MUL_BW-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

### rtl/core/ddo_div.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ddo_div
    import ddo_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    output logic                   o_done,
    output logic [DIV_NW-1:0]      o_quo,
    output logic [DIV_DW-1:0]      o_rem
);
    localparam int CW = $clog2(DIV_NW);

    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
                r_num <= {r_num[DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

### rtl/core/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine in Q.30, one step per cycle.
`default_nettype none
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int STEPS = 24
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_ang i_angle,
    output logic      o_done,
    output t_ang      o_cos,
    output t_ang      o_sin
);
    localparam int N = (STEPS > ATAN_N) ? ATAN_N : STEPS;

    t_ang               r_x;
    t_ang               r_y;
    t_ang               r_z;
    logic               r_flip;
    logic [ATAN_IW-1:0] r_i;
    logic               r_busy;
    logic               r_done;
    t_ang               w_dx;
    t_ang               w_dy;
    t_ang               w_at;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = t_ang'({2'b00, atan_q30(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // fold angles beyond a quarter turn by half a turn
                if (i_angle > HALF_PI_Q30) begin
                    r_z    <= i_angle - PI_Q30;
                    r_flip <= 1'b1;
                end else if (i_angle < -HALF_PI_Q30) begin
                    r_z    <= i_angle + PI_Q30;
                    r_flip <= 1'b1;
                end else begin
                    r_z    <= i_angle;
                    r_flip <= 1'b0;
                end
                r_x    <= GAIN_Q30;
                r_y    <= '0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[ANG_W-1]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == ATAN_IW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule
`default_nettype wire

### rtl/core/diff_drive_odometry_gyro_fusion.sv
// Top level: differential-drive odometry with gyro heading, sequenced over serial units.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one request per tick: both wheel
//   speeds, the gyro yaw rate and the elapsed time dt_us. Output channel
//   (o_out_valid / i_out_ready) returns one result per request: pose, speeds,
//   yaw quaternion and the updated flag.
//   A zero dt_us request goes straight to the output state, where its result is
//   registered once the output register is free. Any other request runs eight
//   bit-serial multiplies, six divides (seven when the heading wraps) and two
//   CORDIC passes, stepped through by the sequencer. One request is in work at a
//   time and o_in_ready is high only while the sequencer is idle, so the next
//   request can be taken in the cycle after the result is registered.
//   The result sits in an output register, so a new request is taken while an
//   earlier result waits; a finished request waits in its last state while the
//   receiver stalls.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once
//   and are expected only while idle. Reset restores register defaults, clears
//   the pose and speeds, sets quat_w to one and drops o_out_valid.
`default_nettype none
module diff_drive_odometry_gyro_fusion
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [23:0] i_left_rpm,
    input  wire logic signed [23:0] i_right_rpm,
    input  wire logic signed [23:0] i_gyro_z,
    input  wire logic [19:0]        i_dt_us,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [47:0]      o_pos_x,
    output logic signed [47:0]      o_pos_y,
    output logic signed [30:0]      o_heading,
    output logic signed [31:0]      o_lin_speed,
    output logic signed [31:0]      o_turn_rate,
    output logic signed [31:0]      o_quat_w,
    output logic signed [31:0]      o_quat_z,
    output logic                    o_updated
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MV   = 5'd1;
    localparam logic [4:0] S_DV   = 5'd2;
    localparam logic [4:0] S_MW   = 5'd3;
    localparam logic [4:0] S_DW   = 5'd4;
    localparam logic [4:0] S_MG   = 5'd5;
    localparam logic [4:0] S_DG   = 5'd6;
    localparam logic [4:0] S_MH   = 5'd7;
    localparam logic [4:0] S_DH   = 5'd8;
    localparam logic [4:0] S_WCHK = 5'd9;
    localparam logic [4:0] S_DWR  = 5'd10;
    localparam logic [4:0] S_CP   = 5'd11;
    localparam logic [4:0] S_MX   = 5'd12;
    localparam logic [4:0] S_MXT  = 5'd13;
    localparam logic [4:0] S_DX   = 5'd14;
    localparam logic [4:0] S_MY   = 5'd15;
    localparam logic [4:0] S_MYT  = 5'd16;
    localparam logic [4:0] S_DY   = 5'd17;
    localparam logic [4:0] S_CQ   = 5'd18;
    localparam logic [4:0] S_OUT  = 5'd19;

    localparam logic signed [39:0] PI40   = 40'sd843314857;
    localparam logic [31:0]        TWO_PI = 32'd1686629714;
    localparam logic [31:0]        DEN_V  = 32'd30720;
    localparam logic [31:0]        DEN_G  = 32'd1017;
    localparam logic [31:0]        DEN_H  = 32'd15625;
    localparam logic [31:0]        DEN_P  = 32'd1000000;
    localparam logic [31:0]        GYRO_K = 32'd18176;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [48:0] MAX48 = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] MIN48 = 49'sh1_8000_0000_0000;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47]) begin
            r = v[48] ? MIN48[47:0] : MAX48[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_q(input t_ang v);
        logic signed [31:0] r;
        if (v > t_ang'(ONE_Q30)) begin
            r = ONE_Q30;
        end else if (v < -t_ang'(ONE_Q30)) begin
            r = -ONE_Q30;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // sequencer and request registers
    logic [4:0]         r_state;
    logic               r_iss;
    logic signed [23:0] r_l;
    logic signed [23:0] r_r;
    logic signed [23:0] r_g;
    logic [19:0]        r_dt;
    logic               r_upd;

    // configuration
    logic [23:0] r_circ;
    logic [23:0] r_base;
    logic [23:0] r_ssl;
    logic [23:0] r_stl;
    logic [23:0] r_db;

    // pose state
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;
    logic signed [31:0] r_head;
    logic signed [31:0] r_speed;
    logic signed [31:0] r_rate;
    logic signed [31:0] r_qw;
    logic signed [31:0] r_qz;

    // working values
    logic [34:0]        r_vmag;
    logic               r_wsmall;
    logic signed [39:0] r_h;
    t_ang               r_c;
    t_ang               r_s;
    t_ang               r_t;

    // output register
    logic               r_o_valid;
    logic signed [47:0] r_o_x;
    logic signed [47:0] r_o_y;
    logic signed [30:0] r_o_head;
    logic signed [31:0] r_o_speed;
    logic signed [31:0] r_o_rate;
    logic signed [31:0] r_o_qw;
    logic signed [31:0] r_o_qz;
    logic               r_o_upd;

    logic signed [24:0] w_sum;
    logic signed [24:0] w_dif;
    logic [24:0]        w_sum_mag;
    logic [24:0]        w_dif_mag;
    logic [23:0]        w_g_mag;
    logic [31:0]        w_rate_mag;
    logic [31:0]        w_spd_mag;
    logic [33:0]        w_c_mag;
    logic [33:0]        w_s_mag;
    logic [33:0]        w_t_mag;
    logic [23:0]        w_base1;
    logic [27:0]        w_base15;

    logic               w_is_mul;
    logic               w_is_div;
    logic               w_is_cor;
    logic [MUL_AW-1:0]  w_mul_a;
    logic [MUL_BW-1:0]  w_mul_b;
    logic [DIV_NW-1:0]  w_div_n;
    logic [DIV_DW-1:0]  w_div_d;
    t_ang               w_ang;
    logic               w_mul_done;
    logic               w_div_done;
    logic               w_cor_done;
    logic [MUL_AW-1:0]  w_prod;
    logic [DIV_NW-1:0]  w_quo;
    logic [DIV_DW-1:0]  w_rem;
    t_ang               w_cos;
    t_ang               w_sin;

    logic [34:0]        w_vq;
    logic signed [31:0] w_spd_next;
    logic [27:0]        w_rmag;
    logic               w_still;
    logic signed [31:0] w_rate_next;
    logic signed [39:0] w_hq;
    logic signed [39:0] w_head40;
    logic signed [39:0] w_h_next;
    logic signed [39:0] w_wrap_a;
    logic signed [39:0] w_rem40;
    logic signed [39:0] w_h_wrap;
    logic signed [63:0] w_tprod;
    logic signed [48:0] w_p;
    logic signed [48:0] w_x_sum;
    logic signed [48:0] w_y_sum;

    assign w_sum = {r_l[23], r_l} + {r_r[23], r_r};
    assign w_dif = {r_r[23], r_r} - {r_l[23], r_l};
    assign w_sum_mag  = w_sum[24] ? 25'(-w_sum) : 25'(w_sum);
    assign w_dif_mag  = w_dif[24] ? 25'(-w_dif) : 25'(w_dif);
    assign w_g_mag    = r_g[23] ? 24'(-r_g) : 24'(r_g);
    assign w_rate_mag = r_rate[31] ? 32'(-r_rate) : 32'(r_rate);
    assign w_spd_mag  = r_speed[31] ? 32'(-r_speed) : 32'(r_speed);
    assign w_c_mag    = r_c[ANG_W-1] ? 34'(-r_c) : 34'(r_c);
    assign w_s_mag    = r_s[ANG_W-1] ? 34'(-r_s) : 34'(r_s);
    assign w_t_mag    = r_t[ANG_W-1] ? 34'(-r_t) : 34'(r_t);
    // a zero wheel base counts as one
    assign w_base1    = (r_base == '0) ? 24'd1 : r_base;
    assign w_base15   = {w_base1, 4'd0} - {4'd0, w_base1};

    always_comb begin
        w_is_mul = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state)
            S_MV: begin
                w_is_mul = 1'b1;
                w_mul_a  = MUL_AW'(w_sum_mag);
                w_mul_b  = MUL_BW'(r_circ);
            end
            S_MW: begin
                w_is_mul = 1'b1;
                w_mul_a  = MUL_AW'(w_dif_mag);
                w_mul_b  = MUL_BW'(r_circ);
            end
            S_MG: begin
                w_is_mul = 1'b1;
                w_mul_a  = MUL_AW'(w_g_mag);
                w_mul_b  = GYRO_K;
            end
            S_MH: begin
                w_is_mul = 1'b1;
                w_mul_a  = MUL_AW'(w_rate_mag);
                w_mul_b  = MUL_BW'(r_dt);
            end
            S_MX: begin
                w_is_mul = 1'b1;
                w_mul_a  = MUL_AW'(w_c_mag);
                w_mul_b  = w_spd_mag;
            end
            S_MY: begin
                w_is_mul = 1'b1;
                w_mul_a  = MUL_AW'(w_s_mag);
                w_mul_b  = w_spd_mag;
            end
            S_MXT, S_MYT: begin
                w_is_mul = 1'b1;
                w_mul_a  = MUL_AW'(w_t_mag);
                w_mul_b  = MUL_BW'(r_dt);
            end
            default: begin
                w_is_mul = 1'b0;
            end
        endcase
    end

    // distance past the wrap limit, never negative in the wrap state
    assign w_wrap_a = r_h[39] ? (-r_h - PI40 - 40'sd1) : (r_h - PI40 - 40'sd1);

    always_comb begin
        w_is_div = 1'b0;
        w_div_n  = '0;
        w_div_d  = '0;
        unique case (r_state)
            S_DV: begin
                w_is_div = 1'b1;
                w_div_n  = w_prod;
                w_div_d  = DEN_V;
            end
            S_DW: begin
                w_is_div = 1'b1;
                w_div_n  = {w_prod[DIV_NW-11:0], 10'd0};
                w_div_d  = DIV_DW'(w_base15);
            end
            S_DG: begin
                w_is_div = 1'b1;
                w_div_n  = w_prod;
                w_div_d  = DEN_G;
            end
            S_DH: begin
                w_is_div = 1'b1;
                w_div_n  = {w_prod[DIV_NW-2:0], 1'b0};
                w_div_d  = DEN_H;
            end
            S_DWR: begin
                w_is_div = 1'b1;
                w_div_n  = DIV_NW'(unsigned'(w_wrap_a));
                w_div_d  = TWO_PI;
            end
            S_DX, S_DY: begin
                w_is_div = 1'b1;
                w_div_n  = w_prod;
                w_div_d  = DEN_P;
            end
            default: begin
                w_is_div = 1'b0;
            end
        endcase
    end

    assign w_is_cor = (r_state == S_CP) || (r_state == S_CQ);
    assign w_ang    = (r_state == S_CP) ? t_ang'({r_head, 2'b00})
                                        : t_ang'({r_head[31], r_head, 1'b0});

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_is_mul && !r_iss),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_is_div && !r_iss),
        .i_num   (w_div_n),
        .i_den   (w_div_d),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_is_cor && !r_iss),
        .i_angle (w_ang),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // linear speed, saturated
    assign w_vq = w_quo[34:0];
    always_comb begin
        if (!w_sum[24]) begin
            w_spd_next = (w_vq > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(w_vq[31:0]);
        end else begin
            w_spd_next = (w_vq > 35'h0_8000_0000) ? 32'sh8000_0000 : signed'(-w_vq[31:0]);
        end
    end

    // gyro rate with deadband while still
    assign w_rmag      = w_quo[27:0];
    assign w_still     = (r_vmag < 35'(r_ssl)) && r_wsmall && (w_rmag < 28'(r_db));
    assign w_rate_next = w_still ? 32'sd0
                       : (r_g[23] ? -signed'({4'd0, w_rmag}) : signed'({4'd0, w_rmag}));

    assign w_hq     = signed'({3'd0, w_quo[36:0]});
    assign w_head40 = 40'(r_head);
    assign w_h_next = r_rate[31] ? (w_head40 - w_hq) : (w_head40 + w_hq);
    assign w_rem40  = signed'({8'd0, w_rem});
    assign w_h_wrap = r_h[39] ? (PI40 - 40'sd1 - w_rem40) : (w_rem40 - PI40 + 40'sd1);

    assign w_tprod = ((r_state == S_MY) ? r_s[ANG_W-1] : r_c[ANG_W-1]) ^ r_speed[31]
                   ? -signed'(w_prod) : signed'(w_prod);

    assign w_p     = r_t[ANG_W-1] ? -signed'({13'd0, w_quo[35:0]})
                                  : signed'({13'd0, w_quo[35:0]});
    assign w_x_sum = 49'(r_x) + w_p;
    assign w_y_sum = 49'(r_y) + w_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss     <= 1'b0;
            r_o_valid <= 1'b0;
            r_circ    <= 24'd52276;
            r_base    <= 24'd38400;
            r_ssl     <= 24'd256;
            r_stl     <= 24'd104858;
            r_db      <= 24'd52429;
            r_x       <= '0;
            r_y       <= '0;
            r_head    <= '0;
            r_speed   <= '0;
            r_rate    <= '0;
            r_qw      <= ONE_Q30;
            r_qz      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CIRC:     r_circ <= i_cfg_data;
                    CFG_BASE:     r_base <= i_cfg_data;
                    CFG_STILL_V:  r_ssl  <= i_cfg_data;
                    CFG_STILL_W:  r_stl  <= i_cfg_data;
                    CFG_DEADBAND: r_db   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // the output state reloads the register itself
            if (r_o_valid && i_out_ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_l  <= i_left_rpm;
                        r_r  <= i_right_rpm;
                        r_g  <= i_gyro_z;
                        r_dt <= i_dt_us;
                        if (i_dt_us == '0) begin
                            r_upd   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_upd   <= 1'b1;
                            r_state <= S_MV;
                        end
                    end
                end
                S_MV, S_MW, S_MG, S_MH, S_MXT, S_MYT: begin
                    r_iss <= !w_mul_done;
                    if (w_mul_done) begin
                        unique case (r_state)
                            S_MV:    r_state <= S_DV;
                            S_MW:    r_state <= S_DW;
                            S_MG:    r_state <= S_DG;
                            S_MH:    r_state <= S_DH;
                            S_MXT:   r_state <= S_DX;
                            default: r_state <= S_DY;
                        endcase
                    end
                end
                S_MX, S_MY: begin
                    r_iss <= !w_mul_done;
                    if (w_mul_done) begin
                        // floor of the product scaled back to length units
                        r_t     <= t_ang'(w_tprod[63:30]);
                        r_state <= (r_state == S_MX) ? S_MXT : S_MYT;
                    end
                end
                S_DV: begin
                    r_iss <= !w_div_done;
                    if (w_div_done) begin
                        r_vmag  <= w_vq;
                        r_speed <= w_spd_next;
                        r_state <= S_MW;
                    end
                end
                S_DW: begin
                    r_iss <= !w_div_done;
                    if (w_div_done) begin
                        r_wsmall <= (w_quo < DIV_NW'(r_stl));
                        r_state  <= S_MG;
                    end
                end
                S_DG: begin
                    r_iss <= !w_div_done;
                    if (w_div_done) begin
                        r_rate  <= w_rate_next;
                        r_state <= S_MH;
                    end
                end
                S_DH: begin
                    r_iss <= !w_div_done;
                    if (w_div_done) begin
                        r_h     <= w_h_next;
                        r_state <= S_WCHK;
                    end
                end
                S_WCHK: begin
                    if ((r_h > PI40) || (r_h < -PI40)) begin
                        r_state <= S_DWR;
                    end else begin
                        r_head  <= r_h[31:0];
                        r_state <= S_CP;
                    end
                end
                S_DWR: begin
                    r_iss <= !w_div_done;
                    if (w_div_done) begin
                        r_head  <= w_h_wrap[31:0];
                        r_state <= S_CP;
                    end
                end
                S_CP: begin
                    r_iss <= !w_cor_done;
                    if (w_cor_done) begin
                        r_c     <= w_cos;
                        r_s     <= w_sin;
                        r_state <= S_MX;
                    end
                end
                S_DX: begin
                    r_iss <= !w_div_done;
                    if (w_div_done) begin
                        r_x     <= sat48(w_x_sum);
                        r_state <= S_MY;
                    end
                end
                S_DY: begin
                    r_iss <= !w_div_done;
                    if (w_div_done) begin
                        r_y     <= sat48(w_y_sum);
                        r_state <= S_CQ;
                    end
                end
                S_CQ: begin
                    r_iss <= !w_cor_done;
                    if (w_cor_done) begin
                        r_qw    <= clamp_q(w_cos);
                        r_qz    <= clamp_q(w_sin);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_x     <= r_x;
                        r_o_y     <= r_y;
                        r_o_head  <= r_head[30:0];
                        r_o_speed <= r_speed;
                        r_o_rate  <= r_rate;
                        r_o_qw    <= r_qw;
                        r_o_qz    <= r_qz;
                        r_o_upd   <= r_upd;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_pos_x     = r_o_x;
    assign o_pos_y     = r_o_y;
    assign o_heading   = r_o_head;
    assign o_lin_speed = r_o_speed;
    assign o_turn_rate = r_o_rate;
    assign o_quat_w    = r_o_qw;
    assign o_quat_z    = r_o_qz;
    assign o_updated   = r_o_upd;

endmodule
`default_nettype wire

### rtl/core/ddo_chk.sv
// Port-level checker for the odometry block, bound to the top level.
`default_nettype none
module ddo_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [47:0] o_pos_x,
    input wire logic signed [47:0] o_pos_y,
    input wire logic signed [30:0] o_heading,
    input wire logic signed [31:0] o_lin_speed,
    input wire logic signed [31:0] o_turn_rate,
    input wire logic signed [31:0] o_quat_w,
    input wire logic signed [31:0] o_quat_z,
    input wire logic               o_updated
);
    // one request in work at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another was in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_heading) && $stable(o_lin_speed)
            && $stable(o_turn_rate) && $stable(o_quat_w) && $stable(o_quat_z)
            && $stable(o_updated)))
        else $error("stalled result changed");

    a_heading_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_heading <= 31'sd843314857) && (o_heading >= -31'sd843314857)))
        else $error("heading outside plus minus pi");

    a_quat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_quat_w <= 32'sd1073741824) && (o_quat_w >= -32'sd1073741824)
            && (o_quat_z <= 32'sd1073741824) && (o_quat_z >= -32'sd1073741824)))
        else $error("quaternion part beyond one");

endmodule

bind diff_drive_odometry_gyro_fusion ddo_chk u_ddo_chk (.*);
`default_nettype wire
